>>> rtl/crrc_pkg.sv
// ----------------------------------------------------------------------------
// crrc_pkg
// Shared types and codes for the command ring reserve/commit block.
// ----------------------------------------------------------------------------
package crrc_pkg;

  // Operation carried by an input beat
  typedef enum logic {
    FN_RESERVE = 1'b0,
    FN_COMMIT  = 1'b1
  } func_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_IN_PLACE   = 3'd0,
    ST_BOUNCE     = 3'd1,
    ST_FULL       = 3'd2,
    ST_TOO_LARGE  = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_ALREADY    = 3'd5,
    ST_NO_RESV    = 3'd6
  } status_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RING_START      = 2'd0,
    CFG_RING_END        = 2'd1,
    CFG_RESERVE_CAPABLE = 2'd2,
    CFG_BOUNCE_LIMIT    = 2'd3
  } cfg_reg_t;

  localparam int FIELD_BITS = 24;

  // Input beat payload
  typedef struct packed {
    func_t                 func;
    logic [FIELD_BITS-1:0] transfer_bytes;
    logic [FIELD_BITS-1:0] host_stop_offset;
  } in_item_t;

  // Result beat payload
  typedef struct packed {
    status_t               status;
    logic [FIELD_BITS-1:0] space_offset;
    logic                  bounce_used;
    logic [FIELD_BITS-1:0] first_chunk;
    logic [FIELD_BITS-1:0] second_chunk;
    logic [FIELD_BITS-1:0] write_offset_out;
    logic [FIELD_BITS-1:0] announced_reserve;
  } out_item_t;

endpackage

>>> rtl/crrc_if.sv
// ----------------------------------------------------------------------------
// crrc channel interfaces
// Valid/ready channels for input beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface crrc_in_if;
  logic               valid;
  logic               ready;
  crrc_pkg::in_item_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface crrc_out_if;
  logic                valid;
  logic                ready;
  crrc_pkg::out_item_t data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface crrc_cfg_if #(parameter int DATA_W = 24);
  logic               valid;
  logic               ready;
  crrc_pkg::cfg_reg_t index;
  logic [DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/crrc_in_reg.sv
// ----------------------------------------------------------------------------
// crrc_in_reg
// Input register stage: holds one beat, refills in the cycle it drains.
// ----------------------------------------------------------------------------
module crrc_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  crrc_pkg::in_item_t up_item,
  output logic               dn_valid,
  input  logic               dn_ready,
  output crrc_pkg::in_item_t dn_item
);

  logic               valid_r;
  crrc_pkg::in_item_t item_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_item  = item_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= up_item;
    end
  end

endmodule

>>> rtl/crrc_engine.sv
// ----------------------------------------------------------------------------
// crrc_engine
// Ring state, configuration registers, reserve/commit decision and result
// register. One beat is evaluated and retired per cycle unless the result stalls.
// ----------------------------------------------------------------------------
module crrc_engine #(
  parameter int OFFSET_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // register writes
  input  logic                      cfg_valid,
  input  crrc_pkg::cfg_reg_t        cfg_index,
  input  logic [OFFSET_BITS-1:0]    cfg_data,
  // item from input register
  input  logic                      in_valid,
  output logic                      in_ready,
  input  crrc_pkg::in_item_t        in_item,
  // result
  output logic                      out_valid,
  input  logic                      out_ready,
  output crrc_pkg::out_item_t       out_item
);

  localparam int FW = crrc_pkg::FIELD_BITS;
  localparam int MW = (OFFSET_BITS > FW) ? OFFSET_BITS : FW;
  localparam int CW = MW + 1;
  localparam int SW = MW + 3;

  // configuration
  logic [OFFSET_BITS-1:0] ring_start_r;
  logic [OFFSET_BITS-1:0] ring_end_r;
  logic                   capable_r;
  logic [OFFSET_BITS-1:0] bounce_limit_r;

  // ring state
  logic [OFFSET_BITS-1:0] wr_off_r, wr_off_nxt;
  logic [OFFSET_BITS-1:0] open_r, open_nxt;
  logic                   bact_r, bact_nxt;

  // result register
  logic                   out_valid_r;
  crrc_pkg::out_item_t    res_r, res_nxt;

  logic fire;

  // working values
  logic [OFFSET_BITS-1:0] size;
  logic [OFFSET_BITS-1:0] room;
  logic [CW-1:0]          bytes_u, limit_u, size_u, room_u;
  logic signed [SW-1:0]   mn_s, mx_s, nx_s, st_s, b_s, adv_s;
  logic                   too_large, misaligned, fit_in, fit_bn;
  logic [FW-1:0]          c1, c2;
  logic [OFFSET_BITS-1:0] wr_adv;
  logic [OFFSET_BITS-1:0] announced;
  crrc_pkg::status_t      st_code;
  logic                   bounce_used;
  logic [FW-1:0]          space_off;

  assign in_ready  = !out_valid_r || out_ready;
  assign fire      = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = res_r;

  // sizes, checks and room tests
  always_comb begin
    size    = (ring_end_r > ring_start_r) ? (ring_end_r - ring_start_r) : '0;
    room    = (ring_end_r > wr_off_r) ? (ring_end_r - wr_off_r) : '0;
    bytes_u = CW'(in_item.transfer_bytes);
    limit_u = CW'(bounce_limit_r);
    size_u  = CW'(size);
    room_u  = CW'(room);

    too_large  = (bytes_u > limit_u) || (bytes_u > size_u);
    misaligned = |in_item.transfer_bytes[1:0];

    mn_s = SW'(ring_start_r);
    mx_s = SW'(ring_end_r);
    nx_s = SW'(wr_off_r);
    st_s = SW'(in_item.host_stop_offset);
    b_s  = SW'(in_item.transfer_bytes);

    // in place or split room
    fit_in = 1'b0;
    fit_bn = 1'b0;
    if (nx_s >= st_s) begin
      if ((nx_s + b_s < mx_s) || ((nx_s + b_s == mx_s) && (st_s > mn_s))) begin
        fit_in = 1'b1;
      end else if ((mx_s - nx_s) + (st_s - mn_s) > b_s) begin
        fit_bn = 1'b1;
      end
    end else if (nx_s + b_s < st_s) begin
      fit_in = 1'b1;
    end

    // bounce commit chunks
    c1 = (bytes_u < room_u) ? in_item.transfer_bytes : FW'(room);
    c2 = in_item.transfer_bytes - c1;

    // offset advance with one wrap
    adv_s = nx_s + b_s;
    if (adv_s >= mx_s) begin
      adv_s = adv_s - (mx_s - mn_s);
    end
    wr_adv = OFFSET_BITS'(adv_s);
  end

  // decision and next state
  always_comb begin
    wr_off_nxt  = wr_off_r;
    open_nxt    = open_r;
    bact_nxt    = bact_r;
    st_code     = crrc_pkg::ST_FULL;
    bounce_used = 1'b0;
    space_off   = '0;
    res_nxt     = '0;

    unique case (in_item.func)
      crrc_pkg::FN_RESERVE: begin
        priority if (too_large) begin
          st_code = crrc_pkg::ST_TOO_LARGE;
        end else if (misaligned) begin
          st_code = crrc_pkg::ST_MISALIGNED;
        end else if (open_r != '0) begin
          st_code = crrc_pkg::ST_ALREADY;
        end else if (fit_in && (capable_r || (bytes_u <= CW'(4)))) begin
          st_code   = crrc_pkg::ST_IN_PLACE;
          space_off = FW'(wr_off_r);
          open_nxt  = OFFSET_BITS'(in_item.transfer_bytes);
          bact_nxt  = 1'b0;
        end else if (fit_in || fit_bn) begin
          st_code     = crrc_pkg::ST_BOUNCE;
          bounce_used = 1'b1;
          open_nxt    = OFFSET_BITS'(in_item.transfer_bytes);
          bact_nxt    = 1'b1;
        end else begin
          st_code = crrc_pkg::ST_FULL;
        end
      end
      crrc_pkg::FN_COMMIT: begin
        if (open_r == '0) begin
          st_code = crrc_pkg::ST_NO_RESV;
        end else begin
          st_code     = crrc_pkg::ST_IN_PLACE;
          bounce_used = bact_r;
          wr_off_nxt  = wr_adv;
          open_nxt    = '0;
          bact_nxt    = 1'b0;
        end
      end
      default: begin
        st_code = crrc_pkg::ST_FULL;
      end
    endcase

    announced = ((open_nxt != '0) && !bact_nxt && capable_r) ? open_nxt : '0;

    res_nxt.status            = st_code;
    res_nxt.space_offset      = space_off;
    res_nxt.bounce_used       = bounce_used;
    res_nxt.first_chunk       = (in_item.func == crrc_pkg::FN_COMMIT && bounce_used) ? c1 : '0;
    res_nxt.second_chunk      = (in_item.func == crrc_pkg::FN_COMMIT && bounce_used) ? c2 : '0;
    res_nxt.write_offset_out  = FW'(wr_off_nxt);
    res_nxt.announced_reserve = FW'(announced);
  end

  // state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_start_r   <= '0;
      ring_end_r     <= OFFSET_BITS'(4096);
      capable_r      <= 1'b0;
      bounce_limit_r <= OFFSET_BITS'(1024);
      wr_off_r       <= '0;
      open_r         <= '0;
      bact_r         <= 1'b0;
    end else begin
      if (fire) begin
        open_r   <= open_nxt;
        bact_r   <= bact_nxt;
      end
      // a ring start write also reloads the write offset
      if (cfg_valid && cfg_index == crrc_pkg::CFG_RING_START) begin
        wr_off_r <= cfg_data;
      end else if (fire) begin
        wr_off_r <= wr_off_nxt;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          crrc_pkg::CFG_RING_START:      ring_start_r   <= cfg_data;
          crrc_pkg::CFG_RING_END:        ring_end_r     <= cfg_data;
          crrc_pkg::CFG_RESERVE_CAPABLE: capable_r      <= cfg_data[0];
          crrc_pkg::CFG_BOUNCE_LIMIT:    bounce_limit_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  // rejected or full beats leave the ring state alone
  a_err_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cfg_valid && (st_code == crrc_pkg::ST_FULL ||
      st_code == crrc_pkg::ST_TOO_LARGE || st_code == crrc_pkg::ST_MISALIGNED ||
      st_code == crrc_pkg::ST_ALREADY || st_code == crrc_pkg::ST_NO_RESV)
    |=> $stable(wr_off_r) && $stable(open_r) && $stable(bact_r))
    else $error("error or full beat changed ring state");

  // a commit always closes the reservation
  a_commit_closes: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !cfg_valid && in_item.func == crrc_pkg::FN_COMMIT |=> open_r == '0)
    else $error("reservation still open after commit");

  // an announced reservation is never a bounce one
  a_announce_in_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.announced_reserve != '0 |-> !res_r.bounce_used)
    else $error("bounce reservation announced to host");

endmodule

>>> rtl/command_ring_reserve_commit_top.sv
// ----------------------------------------------------------------------------
// command_ring_reserve_commit_top
// Latency: a result beat passes the input register, then the decision logic
// into the result register. Throughput: one item per cycle unless the output
// stalls; the ring state registers feed the decision logic directly.
// Reset: synchronous active-low; ring_start 0, ring_end 4096, bounce_limit
// 1024, write offset 0, no reservation open. No clearing pass.
// ----------------------------------------------------------------------------
module command_ring_reserve_commit_top #(
  parameter int OFFSET_BITS = 24
) (
  input logic        clk,
  input logic        rst_n,
  crrc_in_if.sink    in_chan,
  crrc_out_if.source out_chan,
  crrc_cfg_if.sink   cfg_chan
);

  logic                   q_valid;
  logic                   q_ready;
  crrc_pkg::in_item_t     q_item;
  logic [OFFSET_BITS-1:0] cfg_data;

  // register writes are always taken
  assign cfg_chan.ready = 1'b1;
  assign cfg_data       = OFFSET_BITS'(cfg_chan.data);

  // input register
  crrc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_item  (in_chan.data),
    .dn_valid (q_valid),
    .dn_ready (q_ready),
    .dn_item  (q_item)
  );

  // decision, state and result register
  crrc_engine #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_chan.valid),
    .cfg_index (cfg_chan.index),
    .cfg_data  (cfg_data),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_item  (out_chan.data)
  );

endmodule
